// ===== src/tw_pkg.sv =====
// Shared constants, codes and types for the eased tween interpolator.
package tw_pkg;

   localparam int TIME_WIDTH          = 24;
   localparam int PHASE_FRACTION_BITS = 16;

   localparam int VALUE_WIDTH = 32;
   localparam int DUR_WIDTH   = 24;
   localparam int MODE_WIDTH  = 2;
   localparam int CMD_WIDTH   = 2;
   localparam int DELTA_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int CMP_WIDTH = (TIME_WIDTH > DUR_WIDTH) ? TIME_WIDTH : DUR_WIDTH;
   localparam int SUM_WIDTH = ((TIME_WIDTH > DELTA_WIDTH) ? TIME_WIDTH : DELTA_WIDTH) + 1;

   localparam int PHASE_WIDTH = PHASE_FRACTION_BITS;
   localparam int EASE_WIDTH  = PHASE_FRACTION_BITS + 1;

   localparam int MUL_A_WIDTH   = VALUE_WIDTH + 1;
   localparam int MUL_ACC_WIDTH = MUL_A_WIDTH + 1;
   localparam int MUL_STEPS     = EASE_WIDTH;
   localparam int MUL_CNT_WIDTH = $clog2(MUL_STEPS + 1);
   localparam int DIV_CNT_WIDTH = $clog2(PHASE_WIDTH + 1);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
   localparam logic [EASE_WIDTH-1:0] PHASE_ONE = EASE_WIDTH'(1) << PHASE_FRACTION_BITS;

   localparam logic [CMD_WIDTH-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_START = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_RESET = 2'd2;

   localparam logic [MODE_WIDTH-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_ACCEL  = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_DECEL  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_SCURVE = 2'd3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_VALUE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_END_VALUE   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DURATION    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_EASING_MODE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQR,
      ST_MUL,
      ST_RESULT
   } state_type;

endpackage

// ===== src/tw_req_if.sv =====
// Request channel interface: command and time step.
interface tw_req_if;
   logic                           valid;
   logic                           ready;
   logic [tw_pkg::CMD_WIDTH-1:0]   cmd;
   logic [tw_pkg::DELTA_WIDTH-1:0] delta_us;

   modport source (output valid, output cmd, output delta_us, input ready);
   modport sink   (input valid, input cmd, input delta_us, output ready);
endinterface

// ===== src/tw_rsp_if.sv =====
// Response channel interface: current value and done flag.
interface tw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tw_pkg::VALUE_WIDTH-1:0] current_value;
   logic                           done_res;

   modport source (output valid, output current_value, output done_res, input ready);
   modport sink   (input valid, input current_value, input done_res, output ready);
endinterface

// ===== src/eased_tween_interpolator_core.sv =====
// Top level of the eased tween interpolator: control, state and channel registers.
//
//  channel | dir | transaction
//  --------+-----+-----------------------------------------------
//  req     | in  | cmd, delta_us (tick, start, reset)
//  rsp     | out | current_value, done_res (one per request)
//  csr     | in  | csr_wr_en, csr_index, csr_wdata (write only)
//
// Start, reset, unused codes and ticks that finish or find the tween finished go straight
// to the result state; a running tick passes the divide, square (quadratic modes only) and
// multiply states, set by the serial divider and the shared serial multiplier, one bit per
// cycle. The response becomes valid as the block returns to idle to take the next request.
// Reset is synchronous and leaves the tween finished at value zero. A stalled response holds
// in its register while the next request is taken and processed.
module eased_tween_interpolator_core (
   input  logic                               clock,
   input  logic                               reset,
   tw_req_if.sink                             req,
   tw_rsp_if.source                           rsp,
   input  logic                               csr_wr_en,
   input  logic [tw_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tw_pkg::VALUE_WIDTH-1:0]     csr_wdata
);

   localparam int F  = tw_pkg::PHASE_FRACTION_BITS;
   localparam int TW = tw_pkg::TIME_WIDTH;
   localparam int VW = tw_pkg::VALUE_WIDTH;
   localparam int CW = tw_pkg::CMP_WIDTH;
   localparam int SW = tw_pkg::SUM_WIDTH;
   localparam int EW = tw_pkg::EASE_WIDTH;
   localparam int AW = tw_pkg::MUL_A_WIDTH;
   localparam int PW = tw_pkg::MUL_ACC_WIDTH + 1;

   tw_pkg::state_type state_ff, state_in;

   logic [VW-1:0]                 start_ff;
   logic [VW-1:0]                 end_ff;
   logic [tw_pkg::DUR_WIDTH-1:0]  dur_ff;
   logic [tw_pkg::MODE_WIDTH-1:0] mode_ff;

   logic [VW-1:0] value_ff, value_in;
   logic [TW-1:0] elapsed_ff, elapsed_in;
   logic          finished_ff, finished_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] rsp_value_ff;
   logic          rsp_done_ff;

   logic          accept;
   logic          tick_run;
   logic          reach;
   logic [SW-1:0] time_sum;
   logic [TW-1:0] elapsed_sat;
   logic          load_rsp;

   logic                          div_start;
   logic                          div_done;
   logic [tw_pkg::PHASE_WIDTH-1:0] phase;
   logic                          mul_start;
   logic                          mul_done;
   logic [AW-1:0]                 mul_a;
   logic [EW-1:0]                 mul_b;
   logic [PW-1:0]                 prod_f;
   logic [PW:0]                   prod_f1;

   logic [EW-1:0] phase_ext;
   logic [EW-1:0] phase_rem;
   logic [EW-1:0] sq_base;
   logic [EW-1:0] ease;
   logic [AW-1:0] span;
   logic [PW-1:0] lerp;

   assign accept = req.valid && req.ready;

   always_comb begin
      time_sum    = SW'(elapsed_ff) + SW'(req.delta_us);
      elapsed_sat = (time_sum > SW'(tw_pkg::TIME_MAX)) ? tw_pkg::TIME_MAX : time_sum[TW-1:0];
      reach       = CW'(elapsed_sat) >= CW'(dur_ff);
      tick_run    = (req.cmd == tw_pkg::CMD_TICK) && !finished_ff;
   end

   always_comb begin
      phase_ext = {1'b0, phase};
      phase_rem = tw_pkg::PHASE_ONE - phase_ext;
      case (mode_ff)
         tw_pkg::MODE_ACCEL: begin
            sq_base = phase_ext;
            ease    = prod_f[EW-1:0];
         end
         tw_pkg::MODE_DECEL: begin
            sq_base = phase_rem;
            ease    = tw_pkg::PHASE_ONE - prod_f[EW-1:0];
         end
         tw_pkg::MODE_SCURVE: begin
            sq_base = phase[F-1] ? phase_rem : phase_ext;
            ease    = phase[F-1] ? (tw_pkg::PHASE_ONE - prod_f1[EW-1:0]) : prod_f1[EW-1:0];
         end
         default: begin
            sq_base = phase_ext;
            ease    = phase_ext;
         end
      endcase
      span = {end_ff[VW-1], end_ff} - {start_ff[VW-1], start_ff};
      lerp = {{(PW-VW){start_ff[VW-1]}}, start_ff} + prod_f;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tw_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (tick_run && !reach) ? tw_pkg::ST_DIV : tw_pkg::ST_RESULT;
            end
         end
         tw_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = (mode_ff == tw_pkg::MODE_LINEAR) ? tw_pkg::ST_MUL : tw_pkg::ST_SQR;
            end
         end
         tw_pkg::ST_SQR: begin
            if (mul_done) begin
               state_in = tw_pkg::ST_MUL;
            end
         end
         tw_pkg::ST_MUL: begin
            if (mul_done) begin
               state_in = tw_pkg::ST_RESULT;
            end
         end
         tw_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = tw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      div_start = 1'b0;
      mul_start = 1'b0;
      load_rsp  = 1'b0;
      mul_a     = span;
      mul_b     = ease;
      case (state_ff)
         tw_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            div_start = req.valid && tick_run && !reach;
         end
         tw_pkg::ST_DIV: begin
            mul_start = div_done;
            if (mode_ff != tw_pkg::MODE_LINEAR) begin
               mul_a = AW'(sq_base);
               mul_b = sq_base;
            end
         end
         tw_pkg::ST_SQR: begin
            mul_start = mul_done;
         end
         tw_pkg::ST_RESULT: begin
            load_rsp = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      value_in    = value_ff;
      elapsed_in  = elapsed_ff;
      finished_in = finished_ff;
      if (accept) begin
         case (req.cmd)
            tw_pkg::CMD_TICK: begin
               if (!finished_ff) begin
                  elapsed_in = elapsed_sat;
                  if (reach) begin
                     value_in    = end_ff;
                     finished_in = 1'b1;
                  end
               end
            end
            tw_pkg::CMD_START: begin
               value_in    = start_ff;
               elapsed_in  = '0;
               finished_in = 1'b0;
            end
            tw_pkg::CMD_RESET: begin
               value_in    = start_ff;
               elapsed_in  = '0;
               finished_in = 1'b1;
            end
            default: begin
               value_in = value_ff;
            end
         endcase
      end else if ((state_ff == tw_pkg::ST_MUL) && mul_done) begin
         value_in = lerp[VW-1:0];
      end
      rsp_valid_in = load_rsp ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tw_pkg::ST_IDLE;
         value_ff     <= '0;
         elapsed_ff   <= '0;
         finished_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         value_ff     <= value_in;
         elapsed_ff   <= elapsed_in;
         finished_ff  <= finished_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_value_ff <= value_ff;
         rsp_done_ff  <= finished_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         dur_ff   <= '0;
         mode_ff  <= tw_pkg::MODE_LINEAR;
      end else if (csr_wr_en) begin
         case (csr_index)
            tw_pkg::REG_START_VALUE: start_ff <= csr_wdata;
            tw_pkg::REG_END_VALUE:   end_ff   <= csr_wdata;
            tw_pkg::REG_DURATION:    dur_ff   <= csr_wdata[tw_pkg::DUR_WIDTH-1:0];
            tw_pkg::REG_EASING_MODE: mode_ff  <= csr_wdata[tw_pkg::MODE_WIDTH-1:0];
            default:                 mode_ff  <= mode_ff;
         endcase
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.current_value = rsp_value_ff;
   assign rsp.done_res      = rsp_done_ff;

   tw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (CW'(elapsed_sat)),
      .divisor  (CW'(dur_ff)),
      .done     (div_done),
      .quotient (phase)
   );

   tw_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .prod_f  (prod_f),
      .prod_f1 (prod_f1)
   );

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tw_pkg::ST_DIV) |-> (!finished_ff && (CW'(elapsed_ff) < CW'(dur_ff))))
      else $error("divide running on a finished or expired tween");

   a_reset_cmd: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.cmd == tw_pkg::CMD_RESET))
      |=> (finished_ff && (value_ff == $past(start_ff))))
      else $error("reset command did not restore start value");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> ((state_ff == tw_pkg::ST_SQR) || (state_ff == tw_pkg::ST_MUL)))
      else $error("multiplier finished outside a multiply state");

endmodule

// ===== src/tw_div.sv =====
// Bit-serial restoring divider producing the fractional phase, one quotient bit per cycle.
module tw_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [tw_pkg::CMP_WIDTH-1:0]   dividend,
   input  logic [tw_pkg::CMP_WIDTH-1:0]   divisor,
   output logic                           done,
   output logic [tw_pkg::PHASE_WIDTH-1:0] quotient
);

   localparam int W = tw_pkg::CMP_WIDTH;
   localparam int F = tw_pkg::PHASE_WIDTH;

   logic [W:0]                         rem_ff, rem_in;
   logic [W-1:0]                       dvs_ff;
   logic [F-1:0]                       quo_ff, quo_in;
   logic [tw_pkg::DIV_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                               done_ff, done_in;
   logic [W:0]                         rem_shift;
   logic                               ge;

   always_comb begin
      rem_shift = {rem_ff[W-1:0], 1'b0};
      ge        = rem_shift >= {1'b0, dvs_ff};
      rem_in    = ge ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
      quo_in    = {quo_ff[F-2:0], ge};
      cnt_in    = cnt_ff - tw_pkg::DIV_CNT_WIDTH'(1);
      done_in   = (cnt_ff == tw_pkg::DIV_CNT_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= tw_pkg::DIV_CNT_WIDTH'(F);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/tw_mul.sv =====
// Bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier.
module tw_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [tw_pkg::MUL_A_WIDTH-1:0]   mcand,
   input  logic [tw_pkg::EASE_WIDTH-1:0]    mplier,
   output logic                             done,
   output logic [tw_pkg::MUL_ACC_WIDTH:0]   prod_f,
   output logic [tw_pkg::MUL_ACC_WIDTH+1:0] prod_f1
);

   localparam int AW = tw_pkg::MUL_A_WIDTH;
   localparam int CW = tw_pkg::MUL_ACC_WIDTH;
   localparam int BW = tw_pkg::EASE_WIDTH;

   logic [AW-1:0]                      a_ff;
   logic [BW-1:0]                      b_ff, b_in;
   logic [CW-1:0]                      acc_ff, acc_in;
   logic [BW-1:0]                      low_ff, low_in;
   logic [tw_pkg::MUL_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                               done_ff, done_in;
   logic [CW:0]                        sum;
   logic [CW:0]                        addend;

   always_comb begin
      addend = b_ff[0] ? {{2{a_ff[AW-1]}}, a_ff} : '0;
      sum    = {acc_ff[CW-1], acc_ff} + addend;
      acc_in = sum[CW:1];
      low_in = {sum[0], low_ff[BW-1:1]};
      b_in   = b_ff >> 1;
      cnt_in = cnt_ff - tw_pkg::MUL_CNT_WIDTH'(1);
      done_in = (cnt_ff == tw_pkg::MUL_CNT_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= tw_pkg::MUL_CNT_WIDTH'(tw_pkg::MUL_STEPS);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= mcand;
         b_ff   <= mplier;
         acc_ff <= '0;
      end else if (cnt_ff != '0) begin
         b_ff   <= b_in;
         acc_ff <= acc_in;
         low_ff <= low_in;
      end
   end

   assign done    = done_ff;
   assign prod_f  = {acc_ff, low_ff[BW-1]};
   assign prod_f1 = {acc_ff, low_ff[BW-1:BW-2]};

endmodule
